>>> hw/rtl/vtxr_pkg.sv
`timescale 1ns / 1ps
package vtxr_pkg;

  localparam int MaxRes = 5;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_ESC   = 4'd1,
    ST_ESC9  = 4'd2,
    ST_PRO2A = 4'd3,
    ST_PRO2B = 4'd4,
    ST_PRO3A = 4'd5,
    ST_PRO3B = 4'd6,
    ST_PRO3C = 4'd7,
    ST_DC3   = 4'd8
  } parse_state_t;

  localparam logic [2:0] K_MODEM  = 3'd0;
  localparam logic [2:0] K_SCREEN = 3'd1;
  localparam logic [2:0] K_SMODE  = 3'd2;
  localparam logic [2:0] K_SCROLL = 3'd3;
  localparam logic [2:0] K_LOWER  = 3'd4;

  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_DC3      = 8'h13;
  localparam logic [7:0] CH_US       = 8'd31;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_REPORT   = 8'h61;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_START    = 8'h69;
  localparam logic [7:0] CH_STOP     = 8'h6A;
  localparam logic [7:0] CH_SCROLL   = 8'h43;
  localparam logic [7:0] CH_LOWER    = 8'h45;
  localparam logic [7:0] CH_OFF      = 8'h60;
  localparam logic [7:0] CH_ON       = 8'h61;
  localparam logic [7:0] CH_SCREEN   = 8'h58;
  localparam logic [7:0] CH_MODEM    = 8'h5A;
  localparam logic [7:0] CH_M2S      = 8'h52;
  localparam logic [7:0] CH_K2X      = 8'h51;
  localparam logic [7:0] CH_MIXED    = 8'h70;
  localparam logic [7:0] CH_VTX      = 8'h71;
  localparam logic [7:0] CH_VTX_ALT  = 8'h5E;
  localparam logic [7:0] CH_ROW_OFS  = 8'h40;
  localparam logic [7:0] CH_COL_OFS  = 8'h41;
  localparam logic [7:0] ID_SOH      = 8'h01;
  localparam logic [7:0] ID_C        = 8'h43;
  localparam logic [7:0] ID_U        = 8'h75;
  localparam logic [7:0] ID_LT       = 8'h3C;
  localparam logic [7:0] ID_EOT      = 8'h04;

  localparam logic [2:0] ROUTE_RESET = 3'b011;

  typedef struct packed {
    logic [7:0] data_in;
    logic       source;
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_out;
    logic       last_flag;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [2:0]              cnt;
    res_t [MaxRes-1:0]       res;
  } bundle_t;

endpackage

>>> hw/rtl/vtxr_front.sv
`timescale 1ns / 1ps
module vtxr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  vtxr_pkg::in_t     item,
  input  logic              accept,
  output vtxr_pkg::bundle_t bundle
);

  vtxr_pkg::parse_state_t state_r [2];
  logic [7:0]             saved_a_r [2];
  logic [7:0]             saved_b_r [2];
  logic [2:0]             route_r;

  vtxr_pkg::parse_state_t state_nxt;
  logic [7:0]             saved_a_nxt;
  logic [7:0]             saved_b_nxt;
  logic [2:0]             route_nxt;
  vtxr_pkg::bundle_t      bundle_nxt;

  function automatic vtxr_pkg::bundle_t add_res(input vtxr_pkg::bundle_t b,
                                                input logic [2:0] kind,
                                                input logic [7:0] data);
    vtxr_pkg::bundle_t r;
    r = b;
    if (r.cnt < 3'(vtxr_pkg::MaxRes)) begin
      r.res[r.cnt].kind = kind;
      r.res[r.cnt].data = data;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic vtxr_pkg::bundle_t route_byte(input vtxr_pkg::bundle_t b,
                                                   input logic [7:0] data,
                                                   input logic src,
                                                   input logic [2:0] route);
    vtxr_pkg::bundle_t r;
    r = b;
    if (!src && route[0]) r = add_res(r, vtxr_pkg::K_MODEM, data);
    if (src ? route[1] : route[2]) r = add_res(r, vtxr_pkg::K_SCREEN, data);
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       src;
    logic [7:0] x;
    logic [7:0] y;
    vtxr_pkg::parse_state_t cur;
    c           = item.data_in;
    src         = item.source;
    cur         = state_r[src];
    x           = saved_a_r[src];
    y           = saved_b_r[src];
    bundle_nxt  = '0;
    state_nxt   = cur;
    saved_a_nxt = x;
    saved_b_nxt = y;
    route_nxt   = route_r;
    if (c != 8'd0) begin
      unique case (cur)
        vtxr_pkg::ST_ESC: begin
          state_nxt = vtxr_pkg::ST_IDLE;
          if (c == vtxr_pkg::CH_NINE) begin
            state_nxt = vtxr_pkg::ST_ESC9;
          end else if (c == vtxr_pkg::CH_COLON) begin
            state_nxt = vtxr_pkg::ST_PRO2A;
          end else if (c == vtxr_pkg::CH_SEMI) begin
            state_nxt = vtxr_pkg::ST_PRO3A;
          end else if (c == vtxr_pkg::CH_REPORT) begin
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::CH_US);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM,
                                 {3'd0, item.cursor_row} + vtxr_pkg::CH_ROW_OFS);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM,
                                 {2'd0, item.cursor_col} + vtxr_pkg::CH_COL_OFS);
          end else begin
            // pass the escape on, then treat the byte as if idle
            bundle_nxt = route_byte(bundle_nxt, vtxr_pkg::CH_ESC, src, route_r);
            if (c == vtxr_pkg::CH_ESC) begin
              state_nxt = vtxr_pkg::ST_ESC;
            end else if (c == vtxr_pkg::CH_DC3) begin
              state_nxt = vtxr_pkg::ST_DC3;
            end else begin
              bundle_nxt = route_byte(bundle_nxt, c, src, route_r);
            end
          end
        end
        vtxr_pkg::ST_ESC9: begin
          if (c == vtxr_pkg::CH_LBRACE) begin
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::ID_SOH);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::ID_C);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::ID_U);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::ID_LT);
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_MODEM, vtxr_pkg::ID_EOT);
          end
          state_nxt = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_PRO2A: begin
          saved_a_nxt = c;
          state_nxt   = vtxr_pkg::ST_PRO2B;
        end
        vtxr_pkg::ST_PRO2B: begin
          if (x == vtxr_pkg::CH_TWO) begin
            if (c == vtxr_pkg::CH_RBRACE) begin
              bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_SMODE, 8'd0);
            end else if (c == vtxr_pkg::CH_TILDE) begin
              bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_SMODE, 8'd1);
            end
          end else if (x == vtxr_pkg::CH_START || x == vtxr_pkg::CH_STOP) begin
            if (c == vtxr_pkg::CH_SCROLL) begin
              bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_SCROLL,
                                   {7'd0, x == vtxr_pkg::CH_START});
            end else if (c == vtxr_pkg::CH_LOWER) begin
              bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_LOWER,
                                   {7'd0, x == vtxr_pkg::CH_START});
            end
          end
          state_nxt = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_PRO3A: begin
          saved_a_nxt = c;
          state_nxt   = vtxr_pkg::ST_PRO3B;
        end
        vtxr_pkg::ST_PRO3B: begin
          saved_b_nxt = c;
          state_nxt   = vtxr_pkg::ST_PRO3C;
        end
        vtxr_pkg::ST_PRO3C: begin
          if (x == vtxr_pkg::CH_OFF || x == vtxr_pkg::CH_ON) begin
            if (y == vtxr_pkg::CH_SCREEN) begin
              if (c == vtxr_pkg::CH_M2S) begin
                route_nxt[1] = (x == vtxr_pkg::CH_ON);
              end else if (c == vtxr_pkg::CH_K2X) begin
                route_nxt[2] = (x == vtxr_pkg::CH_ON);
              end
            end else if (y == vtxr_pkg::CH_MODEM && c == vtxr_pkg::CH_K2X) begin
              route_nxt[0] = (x == vtxr_pkg::CH_ON);
            end
          end
          state_nxt = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_DC3: begin
          if (c == vtxr_pkg::CH_MIXED) begin
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_SMODE, 8'd0);
          end else if (c == vtxr_pkg::CH_VTX || c == vtxr_pkg::CH_VTX_ALT) begin
            bundle_nxt = add_res(bundle_nxt, vtxr_pkg::K_SMODE, 8'd1);
          end else begin
            bundle_nxt = route_byte(bundle_nxt, vtxr_pkg::CH_DC3, src, route_r);
            bundle_nxt = route_byte(bundle_nxt, c, src, route_r);
          end
          state_nxt = vtxr_pkg::ST_IDLE;
        end
        default: begin
          state_nxt = vtxr_pkg::ST_IDLE;
          if (c == vtxr_pkg::CH_ESC) begin
            state_nxt = vtxr_pkg::ST_ESC;
          end else if (c == vtxr_pkg::CH_DC3) begin
            state_nxt = vtxr_pkg::ST_DC3;
          end else begin
            bundle_nxt = route_byte(bundle_nxt, c, src, route_r);
          end
        end
      endcase
    end
  end

  assign bundle = bundle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r[0] <= vtxr_pkg::ST_IDLE;
      state_r[1] <= vtxr_pkg::ST_IDLE;
      route_r    <= vtxr_pkg::ROUTE_RESET;
    end else if (accept) begin
      state_r[item.source] <= state_nxt;
      route_r              <= route_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_a_r[item.source] <= saved_a_nxt;
      saved_b_r[item.source] <= saved_b_nxt;
    end
  end

endmodule

>>> hw/rtl/vtxr_queue.sv
`timescale 1ns / 1ps
module vtxr_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vtxr_pkg::bundle_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output vtxr_pkg::bundle_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtxr_pkg::bundle_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/vtxr_back.sv
`timescale 1ns / 1ps
module vtxr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vtxr_pkg::bundle_t head,
  input  logic              head_valid,
  output logic              head_pop,
  output vtxr_pkg::out_t    out_data,
  output logic              out_valid,
  input  logic              out_pop
);

  logic [2:0]     idx_r;
  logic [2:0]     idx_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  vtxr_pkg::out_t out_r;
  logic           load;
  logic           last;

  // advance when the output register is free or being drained this cycle
  assign load     = head_valid && (!out_valid_r || out_pop);
  assign last     = (idx_r == head.cnt - 3'd1);
  assign head_pop = load && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.kind      <= head.res[idx_r].kind;
      out_r.data_out  <= head.res[idx_r].data;
      out_r.last_flag <= last;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/videotex_escape_router.sv
`timescale 1ns / 1ps
// The first result of an accepted transaction is written to the bundle queue, then to the output register.
// Throughput: one input per cycle while the bundle queue has room; results
// leave one per cycle while out_pop drains them, so an input causing n results holds the output for all n.
// The output register is the limit: at most one result per cycle leaves.
// Reset (rst_n low, synchronous): both parsers idle, routing to defaults, queues empty.
module videotex_escape_router #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  vtxr_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output vtxr_pkg::out_t out_data
);

  vtxr_pkg::bundle_t bundle;
  vtxr_pkg::bundle_t q_head;
  logic              accept;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              out_valid;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  vtxr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_data),
    .accept (accept),
    .bundle (bundle)
  );

  vtxr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && bundle.cnt != 3'd0),
    .push_data (bundle),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  vtxr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .out_data   (out_data),
    .out_valid  (out_valid),
    .out_pop    (out_pop)
  );

  assign out_empty = !out_valid;

`ifndef SYNTH
  // mode results always stand alone
  a_mode_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.kind == vtxr_pkg::K_SMODE ||
                    out_data.kind == vtxr_pkg::K_SCROLL ||
                    out_data.kind == vtxr_pkg::K_LOWER)) |-> out_data.last_flag)
    else $error("mode result not marked last");

  a_back_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |=> !out_empty)
    else $error("output stage idle while a bundle waits");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.kind == vtxr_pkg::K_MODEM ||
                    out_data.kind == vtxr_pkg::K_SCREEN ||
                    out_data.kind == vtxr_pkg::K_SMODE ||
                    out_data.kind == vtxr_pkg::K_SCROLL ||
                    out_data.kind == vtxr_pkg::K_LOWER))
    else $error("result kind out of range");
`endif

endmodule

>>> verif/tb_videotex_escape_router.sv
`timescale 1ns / 1ps
module tb_videotex_escape_router;

  localparam logic SRC_KBD   = 1'b0;
  localparam logic SRC_MODEM = 1'b1;

  logic           clk;
  logic           rst_n;
  logic           in_push;
  logic           in_full;
  vtxr_pkg::in_t  in_data;
  logic           out_empty;
  logic           out_pop;
  vtxr_pkg::out_t out_data;

  // Predicted terminal state, one parser per source
  vtxr_pkg::parse_state_t parser [2];
  logic [7:0]             held [4];
  logic [2:0]             route_map;
  vtxr_pkg::res_t         burst [$];
  vtxr_pkg::out_t         terminal_out_q [$];

  int unsigned send_gap_pct = 31;
  int unsigned take_gap_pct = 87;
  int unsigned items_sent   = 0;
  int unsigned mismatches   = 0;

  videotex_escape_router dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_videotex_escape_router: FAIL");
    $finish;
  end

  function automatic void emit_res(logic [2:0] k, logic [7:0] d);
    vtxr_pkg::res_t r;
    r.kind = k;
    r.data = d;
    burst.push_back(r);
  endfunction

  function automatic void route_plain(logic [7:0] b, logic src);
    if (src == SRC_KBD) begin
      if (route_map[0]) emit_res(vtxr_pkg::K_MODEM, b);
      if (route_map[2]) emit_res(vtxr_pkg::K_SCREEN, b);
    end else if (route_map[1]) begin
      emit_res(vtxr_pkg::K_SCREEN, b);
    end
  endfunction

  function automatic void idle_parse(logic [7:0] c, logic src);
    if (c == vtxr_pkg::CH_ESC) parser[src] = vtxr_pkg::ST_ESC;
    else if (c == vtxr_pkg::CH_DC3) parser[src] = vtxr_pkg::ST_DC3;
    else route_plain(c, src);
  endfunction

  // Work out the results of one accepted byte and queue them in order
  function automatic void parse_and_route(vtxr_pkg::in_t it);
    logic [7:0]     c;
    logic           src;
    logic [7:0]     x;
    logic [7:0]     y;
    logic           on;
    vtxr_pkg::out_t o;
    c   = it.data_in;
    src = it.source;
    burst.delete();
    if (c != 8'd0) begin
      case (parser[src])
        vtxr_pkg::ST_ESC: begin
          parser[src] = vtxr_pkg::ST_IDLE;
          if (c == vtxr_pkg::CH_NINE) parser[src] = vtxr_pkg::ST_ESC9;
          else if (c == vtxr_pkg::CH_COLON) parser[src] = vtxr_pkg::ST_PRO2A;
          else if (c == vtxr_pkg::CH_SEMI) parser[src] = vtxr_pkg::ST_PRO3A;
          else if (c == vtxr_pkg::CH_REPORT) begin
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::CH_US);
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::CH_ROW_OFS + {3'b000, it.cursor_row});
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::CH_COL_OFS + {2'b00, it.cursor_col});
          end else begin
            // pass the ESC on, then handle the follower afresh
            route_plain(vtxr_pkg::CH_ESC, src);
            idle_parse(c, src);
          end
        end
        vtxr_pkg::ST_ESC9: begin
          if (c == vtxr_pkg::CH_LBRACE) begin
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::ID_SOH);
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::ID_C);
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::ID_U);
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::ID_LT);
            emit_res(vtxr_pkg::K_MODEM, vtxr_pkg::ID_EOT);
          end
          parser[src] = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_PRO2A: begin
          held[{src, 1'b0}] = c;
          parser[src] = vtxr_pkg::ST_PRO2B;
        end
        vtxr_pkg::ST_PRO2B: begin
          x = held[{src, 1'b0}];
          if (x == vtxr_pkg::CH_TWO) begin
            if (c == vtxr_pkg::CH_RBRACE) emit_res(vtxr_pkg::K_SMODE, 8'd0);
            else if (c == vtxr_pkg::CH_TILDE) emit_res(vtxr_pkg::K_SMODE, 8'd1);
          end else if (x == vtxr_pkg::CH_START || x == vtxr_pkg::CH_STOP) begin
            on = (x == vtxr_pkg::CH_START);
            if (c == vtxr_pkg::CH_SCROLL) emit_res(vtxr_pkg::K_SCROLL, {7'd0, on});
            else if (c == vtxr_pkg::CH_LOWER) emit_res(vtxr_pkg::K_LOWER, {7'd0, on});
          end
          parser[src] = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_PRO3A: begin
          held[{src, 1'b0}] = c;
          parser[src] = vtxr_pkg::ST_PRO3B;
        end
        vtxr_pkg::ST_PRO3B: begin
          held[{src, 1'b1}] = c;
          parser[src] = vtxr_pkg::ST_PRO3C;
        end
        vtxr_pkg::ST_PRO3C: begin
          x = held[{src, 1'b0}];
          y = held[{src, 1'b1}];
          if (x == vtxr_pkg::CH_OFF || x == vtxr_pkg::CH_ON) begin
            on = (x == vtxr_pkg::CH_ON);
            if (y == vtxr_pkg::CH_SCREEN) begin
              if (c == vtxr_pkg::CH_M2S) route_map[1] = on;
              else if (c == vtxr_pkg::CH_K2X) route_map[2] = on;
            end else if (y == vtxr_pkg::CH_MODEM && c == vtxr_pkg::CH_K2X) begin
              route_map[0] = on;
            end
          end
          parser[src] = vtxr_pkg::ST_IDLE;
        end
        vtxr_pkg::ST_DC3: begin
          if (c == vtxr_pkg::CH_MIXED) emit_res(vtxr_pkg::K_SMODE, 8'd0);
          else if (c == vtxr_pkg::CH_VTX || c == vtxr_pkg::CH_VTX_ALT) begin
            emit_res(vtxr_pkg::K_SMODE, 8'd1);
          end else begin
            route_plain(vtxr_pkg::CH_DC3, src);
            route_plain(c, src);
          end
          parser[src] = vtxr_pkg::ST_IDLE;
        end
        default: begin
          parser[src] = vtxr_pkg::ST_IDLE;
          idle_parse(c, src);
        end
      endcase
    end
    foreach (burst[i]) begin
      o.kind      = burst[i].kind;
      o.data_out  = burst[i].data;
      o.last_flag = (i == burst.size() - 1);
      terminal_out_q.push_back(o);
    end
  endfunction

  function automatic void take_terminal_out(vtxr_pkg::out_t got);
    vtxr_pkg::out_t want;
    if (terminal_out_q.size() == 0) begin
      $display("%0t: unexpected result kind %0d data %02h last %0b",
               $time, got.kind, got.data_out, got.last_flag);
      mismatches++;
    end else begin
      want = terminal_out_q.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
        mismatches++;
      end
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %02h, got %02h",
                 $time, want.data_out, got.data_out);
        mismatches++;
      end
      if (got.last_flag !== want.last_flag) begin
        $display("%0t: last_flag expected %0b, got %0b",
                 $time, want.last_flag, got.last_flag);
        mismatches++;
      end
    end
  endfunction

  // Result side: check on each popped transaction, then choose whether to stall
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) take_terminal_out(out_data);
      out_pop <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Hold push high between back-to-back transactions; drop it only for a gap
  task automatic send_item(vtxr_pkg::in_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    parse_and_route(item);
    if (item.data_in != 8'd0) items_sent++;
  endtask

  task automatic push_byte(logic [7:0] b, logic src);
    vtxr_pkg::in_t it;
    it.data_in    = b;
    it.source     = src;
    it.cursor_row = 5'($urandom_range(24));
    it.cursor_col = 6'($urandom_range(39));
    send_item(it);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 1));
    return b;
  endfunction

  function automatic logic [7:0] one_of(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned p;
    p = $urandom_range(9);
    if (p < 3) return a;
    else if (p < 6) return b;
    else if (p < 9) return c;
    else return rand_byte();
  endfunction

  task automatic test_plain_bytes();
    push_byte(8'h00, SRC_KBD);
    push_byte(8'hFF, SRC_KBD);
    push_byte(8'h01, SRC_MODEM);
  endtask

  task automatic test_escape_reports();
    vtxr_pkg::in_t it;
    push_byte(vtxr_pkg::CH_ESC, SRC_KBD);
    push_byte(vtxr_pkg::CH_ESC, SRC_MODEM);
    it.data_in    = vtxr_pkg::CH_REPORT;
    it.source     = SRC_KBD;
    it.cursor_row = 5'd24;
    it.cursor_col = 6'd39;
    send_item(it);
    push_byte(vtxr_pkg::CH_NINE, SRC_MODEM);
    push_byte(vtxr_pkg::CH_LBRACE, SRC_MODEM);
    // unknown follower: ESC goes out, then the byte itself
    push_byte(vtxr_pkg::CH_ESC, SRC_KBD);
    push_byte(8'h51, SRC_KBD);
  endtask

  task automatic test_pro_commands();
    push_byte(vtxr_pkg::CH_ESC, SRC_MODEM);
    push_byte(vtxr_pkg::CH_COLON, SRC_MODEM);
    push_byte(8'h00, SRC_MODEM);
    push_byte(vtxr_pkg::CH_START, SRC_MODEM);
    push_byte(vtxr_pkg::CH_LOWER, SRC_MODEM);
    push_byte(vtxr_pkg::CH_DC3, SRC_KBD);
    push_byte(vtxr_pkg::CH_VTX_ALT, SRC_KBD);
  endtask

  task automatic test_routing_matrix();
    // switch keyboard-to-modem off; keyboard then has nowhere to go
    push_byte(vtxr_pkg::CH_ESC, SRC_KBD);
    push_byte(vtxr_pkg::CH_SEMI, SRC_KBD);
    push_byte(vtxr_pkg::CH_OFF, SRC_KBD);
    push_byte(vtxr_pkg::CH_MODEM, SRC_KBD);
    push_byte(vtxr_pkg::CH_K2X, SRC_KBD);
    push_byte(8'h78, SRC_KBD);
    push_byte(vtxr_pkg::CH_DC3, SRC_KBD);
    push_byte(8'h41, SRC_KBD);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int          keep;
    logic        src;
    logic [7:0]  seq [$];
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      src = 1'($urandom_range(1));
      seq.delete();
      case ($urandom_range(10))
        0, 1: seq.push_back(rand_byte());
        2: begin
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(vtxr_pkg::CH_REPORT);
        end
        3: begin
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(vtxr_pkg::CH_NINE);
          seq.push_back(one_of(vtxr_pkg::CH_LBRACE, vtxr_pkg::CH_LBRACE, rand_byte()));
        end
        4: begin
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(vtxr_pkg::CH_COLON);
          seq.push_back(one_of(vtxr_pkg::CH_TWO, vtxr_pkg::CH_TWO, rand_byte()));
          seq.push_back(one_of(vtxr_pkg::CH_RBRACE, vtxr_pkg::CH_TILDE, rand_byte()));
        end
        5: begin
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(vtxr_pkg::CH_COLON);
          seq.push_back(one_of(vtxr_pkg::CH_START, vtxr_pkg::CH_STOP,
                               vtxr_pkg::CH_START));
          seq.push_back(one_of(vtxr_pkg::CH_SCROLL, vtxr_pkg::CH_LOWER,
                               vtxr_pkg::CH_SCROLL));
        end
        6, 7: begin
          // lean towards switching routes on so that traffic keeps flowing
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(vtxr_pkg::CH_SEMI);
          seq.push_back(one_of(vtxr_pkg::CH_ON, vtxr_pkg::CH_OFF, vtxr_pkg::CH_ON));
          seq.push_back(one_of(vtxr_pkg::CH_SCREEN, vtxr_pkg::CH_MODEM,
                               vtxr_pkg::CH_MODEM));
          seq.push_back(one_of(vtxr_pkg::CH_M2S, vtxr_pkg::CH_K2X, vtxr_pkg::CH_K2X));
        end
        8: begin
          seq.push_back(vtxr_pkg::CH_DC3);
          seq.push_back(one_of(vtxr_pkg::CH_MIXED, vtxr_pkg::CH_VTX,
                               vtxr_pkg::CH_VTX_ALT));
        end
        9: begin
          seq.push_back(vtxr_pkg::CH_ESC);
          seq.push_back(rand_byte());
        end
        default: seq.push_back(8'h00);
      endcase
      // cut some sequences short so the next one lands mid-parse
      if ($urandom_range(7) == 0) begin
        keep = int'($urandom_range(seq.size(), 1));
        while (seq.size() > keep) void'(seq.pop_back());
      end
      foreach (seq[i]) begin
        if ($urandom_range(9) == 0) push_byte(8'h00, 1'($urandom_range(1)));
        else if ($urandom_range(9) == 0) push_byte(rand_byte(), !src);
        push_byte(seq[i], src);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    parser[0]  = vtxr_pkg::ST_IDLE;
    parser[1]  = vtxr_pkg::ST_IDLE;
    route_map  = vtxr_pkg::ROUTE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_bytes();
    test_escape_reports();
    test_pro_commands();
    test_routing_matrix();
    test_random_traffic(30);
    send_gap_pct = 87;
    take_gap_pct = 31;
    test_random_traffic(30);
    send_gap_pct = 0;
    take_gap_pct = 0;
    test_random_traffic(30);

    in_push <= 1'b0;
    while (terminal_out_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (terminal_out_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, terminal_out_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_videotex_escape_router: PASS");
    end else begin
      $display("tb_videotex_escape_router: FAIL");
    end
    $finish;
  end

endmodule
